FILE: sv/hla_pkg.sv
`timescale 1ns / 1ps
package hla_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // w terms, split multiplier halves, full products, numerators, remainder
  localparam int WW = 2 * WORD_WIDTH + 2;
  localparam int HW = WW - WORD_WIDTH;
  localparam int PW = 2 * WW;
  localparam int SW = 2 * WW + FRAC_BITS + 1;
  localparam int DW = PW + 1;
  localparam int RW = 2 * WW + WORD_WIDTH + FRAC_BITS + 2;
  localparam int LANES = 6;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_SAT      = 2'd2
  } status_t;

  typedef logic signed [WORD_WIDTH-1:0] word_t;
  typedef logic signed [WW-1:0]         wide_t;
  typedef logic signed [PW-1:0]         prod_t;
  typedef logic signed [SW-1:0]         num_t;
  typedef logic [RW-1:0]                rem_t;
  typedef logic [DW-1:0]                dvs_t;

  typedef struct packed {
    logic [2*WORD_WIDTH-1:0]        ll;
    logic signed [WORD_WIDTH+HW:0]  lh;
    logic signed [WORD_WIDTH+HW:0]  hl;
    logic signed [2*HW-1:0]         hh;
  } pp_t;

  typedef struct packed {
    logic [LANES-1:0]                   neg;
    logic [LANES-1:0]                   big;
    logic                               zero;
    dvs_t                               d2;
    rem_t [LANES-1:0]                   rem;
    logic [LANES-1:0][WORD_WIDTH-1:0]   q;
  } div_t;

  function automatic pp_t mul_part(input wide_t a, input wide_t b);
    pp_t p;
    logic [WORD_WIDTH-1:0] al, bl;
    logic signed [HW-1:0] ah, bh;
    al = a[WORD_WIDTH-1:0];
    bl = b[WORD_WIDTH-1:0];
    ah = a[WW-1:WORD_WIDTH];
    bh = b[WW-1:WORD_WIDTH];
    p.ll = al * bl;
    p.lh = $signed({1'b0, al}) * bh;
    p.hl = ah * $signed({1'b0, bl});
    p.hh = ah * bh;
    return p;
  endfunction

  function automatic prod_t mul_sum(input pp_t p);
    prod_t ell, elh, ehl, ehh;
    ell = prod_t'(p.ll);
    elh = PW'(p.lh);
    ehl = PW'(p.hl);
    ehh = PW'(p.hh);
    return ell + (elh <<< WORD_WIDTH) + (ehl <<< WORD_WIDTH) + (ehh <<< (2 * WORD_WIDTH));
  endfunction

  function automatic div_t div_step(input div_t a, input int b);
    div_t r;
    rem_t t;
    r = a;
    t = rem_t'(a.d2) << b;
    for (int l = 0; l < LANES; l++) begin
      if (a.rem[l] >= t) begin
        r.rem[l]  = a.rem[l] - t;
        r.q[l][b] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

FILE: sv/homography_local_affine.sv
`timescale 1ns / 1ps
// Local affine approximation of a homography at a point, all values signed
// Q16.16. The block takes one beat per cycle while in_ready is high and returns
// one result beat per input beat, in order, through WORD_WIDTH + 8 stages:
// seven arithmetic stages, then six dividers that resolve one quotient bit
// per stage, then the output register. A zero projective denominator returns
// zeros with status 1; any saturated value gives status 2. Stalls at the output
// let the empty stages behind it fill.
module homography_local_affine import hla_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  word_t        hom_00,
  input  word_t        hom_01,
  input  word_t        hom_02,
  input  word_t        hom_10,
  input  word_t        hom_11,
  input  word_t        hom_12,
  input  word_t        hom_20,
  input  word_t        hom_21,
  input  word_t        hom_22,
  input  word_t        point_x,
  input  word_t        point_y,
  output logic         out_valid,
  input  logic         out_ready,
  output word_t        lin_00,
  output word_t        lin_01,
  output word_t        lin_10,
  output word_t        lin_11,
  output word_t        shift_x,
  output word_t        shift_y,
  output logic [1:0]   status
);

  localparam int NS = WORD_WIDTH + 8;
  localparam int DS = 7;

  logic [NS-1:0] v, en;

  // stage 1
  logic signed [2*WORD_WIDTH-1:0] s1_p [6];
  logic signed [2*WORD_WIDTH-1:0] s1_p_next [6];
  word_t s1_h00, s1_h01, s1_h02, s1_h10, s1_h11, s1_h12, s1_h20, s1_h21, s1_h22;
  // stage 2
  wide_t s2_w0, s2_w1, s2_w2, s2_lin2;
  word_t s2_h00, s2_h01, s2_h02, s2_h10, s2_h11, s2_h12, s2_h20, s2_h21;
  // stage 3, 4
  pp_t   s3_pp [13];
  logic  s3_zero;
  prod_t s4_p [13];
  logic  s4_zero;
  // stage 5, 6
  num_t  s5_n [LANES];
  prod_t s5_d;
  logic  s5_zero;
  rem_t  s6_num [LANES];
  logic [LANES-1:0] s6_neg;
  dvs_t  s6_d2;
  logic  s6_zero;
  // divider
  div_t  div_s [WORD_WIDTH+1];
  // output
  logic [LANES-1:0][WORD_WIDTH-1:0] res, res_next;
  logic [1:0] stat, stat_next;

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      en[k] = out_ready || ((v | ((NS'(1) << k) - NS'(1))) != {NS{1'b1}});
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_comb begin
    s1_p_next[0] = hom_00 * point_x;
    s1_p_next[1] = hom_01 * point_y;
    s1_p_next[2] = hom_10 * point_x;
    s1_p_next[3] = hom_11 * point_y;
    s1_p_next[4] = hom_20 * point_x;
    s1_p_next[5] = hom_21 * point_y;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_p   <= s1_p_next;
      s1_h00 <= hom_00;
      s1_h01 <= hom_01;
      s1_h02 <= hom_02;
      s1_h10 <= hom_10;
      s1_h11 <= hom_11;
      s1_h12 <= hom_12;
      s1_h20 <= hom_20;
      s1_h21 <= hom_21;
      s1_h22 <= hom_22;
    end
    if (en[1]) begin
      s2_w0   <= WW'(s1_p[0]) + WW'(s1_p[1]) + (WW'(s1_h02) <<< FRAC_BITS);
      s2_w1   <= WW'(s1_p[2]) + WW'(s1_p[3]) + (WW'(s1_h12) <<< FRAC_BITS);
      s2_w2   <= WW'(s1_p[4]) + WW'(s1_p[5]) + (WW'(s1_h22) <<< FRAC_BITS);
      s2_lin2 <= WW'(s1_p[4]) + WW'(s1_p[5]);
      s2_h00  <= s1_h00;
      s2_h01  <= s1_h01;
      s2_h02  <= s1_h02;
      s2_h10  <= s1_h10;
      s2_h11  <= s1_h11;
      s2_h12  <= s1_h12;
      s2_h20  <= s1_h20;
      s2_h21  <= s1_h21;
    end
    if (en[2]) begin
      s3_pp[0]  <= mul_part(WW'(s2_h00), s2_w2);
      s3_pp[1]  <= mul_part(WW'(s2_h01), s2_w2);
      s3_pp[2]  <= mul_part(WW'(s2_h10), s2_w2);
      s3_pp[3]  <= mul_part(WW'(s2_h11), s2_w2);
      s3_pp[4]  <= mul_part(s2_w0, WW'(s2_h20));
      s3_pp[5]  <= mul_part(s2_w0, WW'(s2_h21));
      s3_pp[6]  <= mul_part(s2_w1, WW'(s2_h20));
      s3_pp[7]  <= mul_part(s2_w1, WW'(s2_h21));
      s3_pp[8]  <= mul_part(s2_w2, s2_w2);
      s3_pp[9]  <= mul_part(s2_w0, s2_lin2);
      s3_pp[10] <= mul_part(s2_w1, s2_lin2);
      s3_pp[11] <= mul_part(WW'(s2_h02) <<< FRAC_BITS, s2_w2);
      s3_pp[12] <= mul_part(WW'(s2_h12) <<< FRAC_BITS, s2_w2);
      s3_zero   <= (s2_w2 == '0);
    end
    if (en[3]) begin
      for (int i = 0; i < 13; i++) begin
        s4_p[i] <= mul_sum(s3_pp[i]);
      end
      s4_zero <= s3_zero;
    end
    if (en[4]) begin
      for (int i = 0; i < 4; i++) begin
        s5_n[i] <= (SW'(s4_p[i]) - SW'(s4_p[4+i])) <<< (2 * FRAC_BITS);
      end
      s5_n[4] <= (SW'(s4_p[9]) + SW'(s4_p[11])) <<< FRAC_BITS;
      s5_n[5] <= (SW'(s4_p[10]) + SW'(s4_p[12])) <<< FRAC_BITS;
      s5_d    <= s4_p[8];
      s5_zero <= s4_zero;
    end
    if (en[5]) begin
      for (int l = 0; l < LANES; l++) begin
        s6_neg[l] <= s5_n[l][SW-1];
        if (s5_n[l][SW-1]) begin
          s6_num[l] <= rem_t'(s5_d) - (rem_t'(s5_n[l]) << 1);
        end else begin
          s6_num[l] <= rem_t'(s5_d) + (rem_t'(s5_n[l]) << 1);
        end
      end
      s6_d2   <= dvs_t'(s5_d) << 1;
      s6_zero <= s5_zero;
    end
    if (en[6]) begin
      for (int l = 0; l < LANES; l++) begin
        div_s[0].rem[l] <= s6_num[l];
        div_s[0].big[l] <= s6_num[l] >= (rem_t'(s6_d2) << WORD_WIDTH);
      end
      div_s[0].q    <= '0;
      div_s[0].neg  <= s6_neg;
      div_s[0].d2   <= s6_d2;
      div_s[0].zero <= s6_zero;
    end
    for (int k = 0; k < WORD_WIDTH; k++) begin
      if (en[DS+k]) begin
        div_s[k+1] <= div_step(div_s[k], WORD_WIDTH - 1 - k);
      end
    end
    if (en[NS-1]) begin
      res  <= res_next;
      stat <= stat_next;
    end
  end

  always_comb begin
    logic [WORD_WIDTH-1:0] lim, val;
    logic sat, sat_any;
    sat_any = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      if (div_s[WORD_WIDTH].neg[l]) begin
        lim = {1'b1, {(WORD_WIDTH-1){1'b0}}};
      end else begin
        lim = {1'b0, {(WORD_WIDTH-1){1'b1}}};
      end
      sat = div_s[WORD_WIDTH].big[l] || (div_s[WORD_WIDTH].q[l] > lim);
      val = sat ? lim : div_s[WORD_WIDTH].q[l];
      res_next[l] = div_s[WORD_WIDTH].neg[l] ? -val : val;
      sat_any = sat_any | sat;
    end
    if (div_s[WORD_WIDTH].zero) begin
      res_next  = '0;
      stat_next = ST_ZERO_DEN;
    end else if (sat_any) begin
      stat_next = ST_SAT;
    end else begin
      stat_next = ST_OK;
    end
  end

  assign lin_00  = $signed(res[0]);
  assign lin_01  = $signed(res[1]);
  assign lin_10  = $signed(res[2]);
  assign lin_11  = $signed(res[3]);
  assign shift_x = $signed(res[4]);
  assign shift_y = $signed(res[5]);
  assign status  = stat;

endmodule

FILE: sv/hla_check.sv
`timescale 1ns / 1ps
module hla_check import hla_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input word_t      lin_00,
  input word_t      lin_01,
  input word_t      lin_10,
  input word_t      lin_11,
  input word_t      shift_x,
  input word_t      shift_y,
  input logic [1:0] status
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(lin_00) && $stable(shift_y)
      && $stable(status))
    else $error("stalled result beat changed");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result beat straight after reset");

  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ST_OK || status == ST_ZERO_DEN || status == ST_SAT)
    else $error("unknown status code");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_ZERO_DEN |-> lin_00 == 0 && lin_01 == 0 && lin_10 == 0
      && lin_11 == 0 && shift_x == 0 && shift_y == 0)
    else $error("zero denominator with non-zero values");

endmodule

bind homography_local_affine hla_check u_hla_check (.*);

FILE: bench/hla_checker.sv
`timescale 1ns / 1ps
module hla_checker import hla_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  word_t      hom_00, hom_01, hom_02,
  input  word_t      hom_10, hom_11, hom_12,
  input  word_t      hom_20, hom_21, hom_22,
  input  word_t      point_x,
  input  word_t      point_y,
  input  logic       out_valid,
  input  logic       out_ready,
  input  word_t      lin_00, lin_01, lin_10, lin_11,
  input  word_t      shift_x,
  input  word_t      shift_y,
  input  logic [1:0] status,
  output int         errors,
  output int         pending
);

  typedef logic signed [255:0] exact_t;

  typedef struct {
    word_t     val[6];
    status_t   st;
  } affine_t;

  affine_t affine_q[$];

  function automatic word_t round_div(input exact_t n, input exact_t d, inout bit sat);
    bit     neg;
    exact_t m, q, lim;
    neg = n < 0;
    m   = neg ? -n : n;
    q   = (2 * m + d) / (2 * d);
    lim = (exact_t'(1) <<< (WORD_WIDTH - 1)) - (neg ? 0 : 1);
    if (q > lim) begin
      q   = lim;
      sat = 1'b1;
    end
    if (neg)
      q = -q;
    return word_t'(q[WORD_WIDTH-1:0]);
  endfunction

  function automatic affine_t local_affine(input word_t h[9], input word_t px, input word_t py);
    affine_t r;
    exact_t  eh[9], ex, ey, w[3], lin2, den, nm;
    bit      sat;
    sat = 1'b0;
    for (int i = 0; i < 9; i++)
      eh[i] = h[i];
    ex = px;
    ey = py;
    for (int i = 0; i < 3; i++)
      w[i] = eh[3*i] * ex + eh[3*i+1] * ey + (eh[3*i+2] <<< FRAC_BITS);
    lin2 = eh[6] * ex + eh[7] * ey;
    if (w[2] == 0) begin
      for (int k = 0; k < 6; k++)
        r.val[k] = '0;
      r.st = ST_ZERO_DEN;
      return r;
    end
    den = w[2] * w[2];
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        nm = (eh[3*i+j] * w[2] - w[i] * eh[6+j]) <<< (2 * FRAC_BITS);
        r.val[2*i+j] = round_div(nm, den, sat);
      end
      nm = (w[i] * lin2 + (eh[3*i+2] <<< FRAC_BITS) * w[2]) <<< FRAC_BITS;
      r.val[4+i] = round_div(nm, den, sat);
    end
    r.st = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  assign pending = affine_q.size();

  always @(posedge clk) begin
    word_t   h[9];
    word_t   got[6];
    affine_t exp_r;
    int      bad;
    bad = 0;
    if (rst) begin
      errors <= 0;
    end else begin
      if (in_valid && in_ready) begin
        h = '{hom_00, hom_01, hom_02, hom_10, hom_11, hom_12, hom_20, hom_21, hom_22};
        affine_q.push_back(local_affine(h, point_x, point_y));
      end
      if (out_valid && out_ready) begin
        if (affine_q.size() == 0) begin
          $display("%0t: unexpected result beat", $time);
          bad++;
        end else begin
          exp_r = affine_q.pop_front();
          got = '{lin_00, lin_01, lin_10, lin_11, shift_x, shift_y};
          for (int k = 0; k < 6; k++)
            if (got[k] !== exp_r.val[k]) begin
              $display("%0t: field %0d expected %h actual %h", $time, k, exp_r.val[k], got[k]);
              bad++;
            end
          if (status !== exp_r.st) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.st, status);
            bad++;
          end
        end
      end
      errors <= errors + bad;
    end
  end

endmodule

FILE: bench/tb_homography_local_affine.sv
`timescale 1ns / 1ps
module tb_homography_local_affine;
  import hla_pkg::*;

  localparam word_t ONE  = 32'sh0001_0000;
  localparam word_t WMAX = 32'sh7fff_ffff;
  localparam word_t WMIN = 32'sh8000_0000;

  logic       clk, rst;
  logic       in_valid, in_ready, out_valid, out_ready;
  word_t      h[9];
  word_t      px, py;
  word_t      lin_00, lin_01, lin_10, lin_11, shift_x, shift_y;
  logic [1:0] status;
  int         errors, pending;

  homography_local_affine u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .hom_00(h[0]), .hom_01(h[1]), .hom_02(h[2]),
    .hom_10(h[3]), .hom_11(h[4]), .hom_12(h[5]),
    .hom_20(h[6]), .hom_21(h[7]), .hom_22(h[8]),
    .point_x(px), .point_y(py),
    .out_valid(out_valid), .out_ready(out_ready),
    .lin_00(lin_00), .lin_01(lin_01), .lin_10(lin_10), .lin_11(lin_11),
    .shift_x(shift_x), .shift_y(shift_y), .status(status)
  );

  hla_checker u_chk (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .hom_00(h[0]), .hom_01(h[1]), .hom_02(h[2]),
    .hom_10(h[3]), .hom_11(h[4]), .hom_12(h[5]),
    .hom_20(h[6]), .hom_21(h[7]), .hom_22(h[8]),
    .point_x(px), .point_y(py),
    .out_valid(out_valid), .out_ready(out_ready),
    .lin_00(lin_00), .lin_01(lin_01), .lin_10(lin_10), .lin_11(lin_11),
    .shift_x(shift_x), .shift_y(shift_y), .status(status),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("homography_local_affine verification failed");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic word_t near(input word_t base, input int span);
    return base + word_t'($urandom_range(0, 2 * span)) - word_t'(span);
  endfunction

  function automatic word_t extreme();
    case ($urandom_range(0, 5))
      0: return WMAX;
      1: return WMIN;
      2: return '0;
      3: return ONE;
      4: return -ONE;
      default: return $urandom;
    endcase
  endfunction

  task automatic send(input word_t hh[9], input word_t x, input word_t y);
    int g;
    @(negedge clk);
    h = hh; px = x; py = y;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    g = gap_len();
    if (g > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  // output side: runs of ready, short stalls and the odd long stall
  initial begin
    int r, n;
    out_ready = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        n = $urandom_range(1, 30);
        out_ready = 1'b1;
      end else if (r < 95) begin
        n = $urandom_range(1, 3);
        out_ready = 1'b0;
      end else begin
        n = $urandom_range(20, 80);
        out_ready = 1'b0;
      end
      repeat (n) @(negedge clk);
    end
  end

  initial begin
    word_t hh[9];
    word_t x, y;
    int    r;
    in_valid = 1'b0;
    h = '{default: '0};
    px = '0; py = '0;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // identity, zero denominator, extremes, saturation
    send('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}, 3 * ONE, -5 * ONE);
    send('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}, WMAX, WMIN);
    send('{ONE, ONE, ONE, ONE, ONE, ONE, 0, 0, 0}, ONE, ONE);
    send('{ONE, 2, 3, 4, 5, 6, ONE, ONE, -2 * ONE}, ONE, ONE);
    send('{WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX}, WMAX, WMAX);
    send('{WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN}, WMIN, WMIN);
    send('{WMIN, WMAX, WMIN, WMAX, WMIN, WMAX, WMIN, WMAX, WMIN}, WMAX, WMIN);
    send('{WMAX, 0, WMAX, 0, WMAX, WMIN, 0, 0, 1}, 0, 0);
    send('{ONE, 0, 0, 0, ONE, 0, 0, 0, 1}, 0, 0);
    send('{1, 1, 1, 1, 1, 1, 1, 1, 1}, 1, 1);
    send('{-1, -1, -1, -1, -1, -1, -1, -1, -1}, -1, -1);
    send('{2 * ONE, 0, ONE, 0, 3 * ONE, 0, 0, 0, 3 * ONE}, ONE, ONE);
    send('{ONE, 0, 0, 0, ONE, 0, 100, 200, ONE}, 50 * ONE, -70 * ONE);
    send('{0, 0, 0, 0, 0, 0, 0, 0, 0}, WMAX, WMIN);
    send('{ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE}, ONE, -ONE);

    for (int i = 0; i < 1500; i++) begin
      if (i == 700) begin
        @(negedge clk);
        in_valid = 1'b0;
        wait (pending == 0);
      end
      r = $urandom_range(0, 99);
      if (r < 50) begin
        hh[0] = near(ONE, 20000); hh[1] = near(0, 20000); hh[2] = near(0, 200 * ONE);
        hh[3] = near(0, 20000);   hh[4] = near(ONE, 20000); hh[5] = near(0, 200 * ONE);
        hh[6] = near(0, 40);      hh[7] = near(0, 40);    hh[8] = near(ONE, 8000);
        x = near(0, 1000 * ONE);
        y = near(0, 1000 * ONE);
      end else if (r < 75) begin
        foreach (hh[k]) hh[k] = $urandom;
        x = $urandom;
        y = $urandom;
      end else if (r < 90) begin
        foreach (hh[k]) hh[k] = extreme();
        x = extreme();
        y = extreme();
      end else begin
        foreach (hh[k]) hh[k] = $urandom;
        hh[8] = '0;
        x = '0;
        y = '0;
        if ($urandom_range(0, 1)) begin
          hh[6] = '0;
          hh[7] = '0;
          x = $urandom;
          y = $urandom;
        end
      end
      send(hh, x, y);
    end
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (60) @(posedge clk);
    if (errors == 0)
      $display("homography_local_affine verification clean");
    else
      $display("homography_local_affine verification failed");
    $finish;
  end

endmodule
